FILE: src/lmsd_pkg.sv
// Shared types and constants for the LED matrix scan driver.
package lmsd_pkg;

  localparam int COLUMNS_DEF       = 64;
  localparam int ROW_ADDRESSES_DEF = 16;
  localparam int PLANES_DEF        = 2;

  localparam int PIXEL_W   = 6;
  localparam int ROW_OUT_W = 4;
  localparam int COL_W     = 6;
  localparam int REQ_W     = 2;

  localparam logic [PIXEL_W-1:0] PIXEL_MASK  = 6'h3F;
  localparam logic [PIXEL_W-1:0] BLANK_PIXEL = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_SELECT = 2'd2
  } lmsd_req_t;

  // strobes from the scan controller to the frame memory
  typedef struct packed {
    logic we;
    logic re;
  } lmsd_mem_ctl_t;

endpackage

FILE: src/lmsd_frame_mem.sv
// Frame store: one write port, one read port with registered read data.
module lmsd_frame_mem import lmsd_pkg::*; #(
  parameter int DEPTH = PLANES_DEF * ROW_ADDRESSES_DEF * COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  lmsd_mem_ctl_t      ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [PIXEL_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_r;

  // read data holds until the next read strobe
  always_ff @(posedge clk) begin
    if (ctl.we) mem[waddr] <= wdata;
    if (ctl.re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/lmsd_scan_ctl.sv
// Scan controller: store clear, request decode, row sequencing and output stage.
module lmsd_scan_ctl import lmsd_pkg::*; #(
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int ROW_ADDRESSES = ROW_ADDRESSES_DEF,
  parameter int PLANES        = PLANES_DEF,
  parameter int DEPTH         = PLANES * ROW_ADDRESSES * COLUMNS,
  parameter int AW            = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic                 in_hold_plane,
  input  logic                 in_plane,
  input  logic [3:0]           in_row,
  input  logic [COL_W-1:0]     in_column,
  input  logic [PIXEL_W-1:0]   in_pixel_bits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_OUT_W-1:0] out_row_address,
  output logic [COL_W-1:0]     out_column,
  output logic [PIXEL_W-1:0]   out_bits,
  output logic                 out_last,
  output lmsd_mem_ctl_t        mem_ctl,
  output logic [AW-1:0]        mem_waddr,
  output logic [PIXEL_W-1:0]   mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [PIXEL_W-1:0]   mem_rdata
);

  localparam int RW = (ROW_ADDRESSES > 1) ? $clog2(ROW_ADDRESSES) : 1;
  localparam int CW = $clog2(COLUMNS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN} state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [RW-1:0]        scan_row_r, scan_row_nxt;
  logic                 shown_r, shown_nxt;
  logic [ROW_OUT_W-1:0] lat_row_r, lat_row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [CW-1:0]        rd_col_r, rd_col_nxt;
  logic                 rd_last_r, rd_last_nxt;
  logic [ROW_OUT_W-1:0] rd_row_r, rd_row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [PIXEL_W-1:0]   out_bits_r, out_bits_nxt;
  logic                 out_last_r, out_last_nxt;

  logic accept, move, issue, col_end;

  function automatic logic [AW-1:0] store_addr(logic p, logic [31:0] r, logic [31:0] c);
    return AW'((32'(p) * ROW_ADDRESSES + r) * COLUMNS + c);
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // read data register doubles as a skid slot ahead of the output register
  assign move     = rd_pend_r && (!out_valid_r || out_ready);
  assign issue    = (state_r == ST_SCAN) && (!rd_pend_r || move);
  assign col_end  = (col_r == CW'(COLUMNS - 1));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    scan_row_nxt  = scan_row_r;
    shown_nxt     = shown_r;
    lat_row_nxt   = lat_row_r;
    col_nxt       = col_r;
    rd_pend_nxt   = rd_pend_r;
    rd_col_nxt    = rd_col_r;
    rd_last_nxt   = rd_last_r;
    rd_row_nxt    = rd_row_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    mem_ctl       = '0;
    mem_waddr     = clr_r;
    mem_wdata     = BLANK_PIXEL;
    mem_raddr     = store_addr(shown_r, 32'(scan_row_r), 32'(col_r));

    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (lmsd_req_t'(in_req_type))
            REQ_WRITE: begin
              if (32'(in_plane) < PLANES && 32'(in_row) < ROW_ADDRESSES &&
                  32'(in_column) < COLUMNS) begin
                mem_ctl.we = 1'b1;
                mem_waddr  = store_addr(in_plane, 32'(in_row), 32'(in_column));
                mem_wdata  = in_pixel_bits & PIXEL_MASK;
              end
            end
            REQ_SELECT: begin
              if (32'(in_plane) < PLANES) shown_nxt = in_plane;
            end
            REQ_TICK: begin
              lat_row_nxt = ROW_OUT_W'(scan_row_r);
              col_nxt     = '0;
              state_nxt   = ST_SCAN;
              if (scan_row_r == RW'(ROW_ADDRESSES - 1)) begin
                scan_row_nxt = '0;
                if (!in_hold_plane)
                  shown_nxt = (shown_r == 1'(PLANES - 1)) ? 1'b0 : shown_r + 1'b1;
              end else begin
                scan_row_nxt = scan_row_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          mem_ctl.re = 1'b1;
          col_nxt    = col_r + 1'b1;
          if (col_end) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (move) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = rd_row_r;
      out_col_nxt   = COL_W'(rd_col_r);
      out_bits_nxt  = mem_rdata;
      out_last_nxt  = rd_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (issue) begin
      rd_pend_nxt = 1'b1;
      rd_col_nxt  = col_r;
      rd_last_nxt = col_end;
      rd_row_nxt  = lat_row_r;
    end else if (move) begin
      rd_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      scan_row_r  <= '0;
      shown_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_row_r  <= scan_row_nxt;
      shown_r     <= shown_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lat_row_r  <= lat_row_nxt;
    col_r      <= col_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_last_r  <= rd_last_nxt;
    rd_row_r   <= rd_row_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row_address = out_row_r;
  assign out_column      = out_col_r;
  assign out_bits        = out_bits_r;
  assign out_last        = out_last_r;

endmodule

FILE: src/led_matrix_scan_driver.sv
// Top level: LED matrix scan driver, controller plus frame memory.
// Write and select items are taken without leaving the idle state; after a tick the next item
// is accepted once every column of the line has been read, later when the output stalls.
// The first pixel of a tick passes through the frame memory read register and the output
// register, then one per clock while out_ready stays high. After reset the frame store is
// cleared to blank, one entry per cycle, with in_ready low.
module led_matrix_scan_driver import lmsd_pkg::*; #(
  parameter int COLUMNS       = COLUMNS_DEF,
  parameter int ROW_ADDRESSES = ROW_ADDRESSES_DEF,
  parameter int PLANES        = PLANES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic                 in_hold_plane,
  input  logic                 in_plane,
  input  logic [3:0]           in_row,
  input  logic [COL_W-1:0]     in_column,
  input  logic [PIXEL_W-1:0]   in_pixel_bits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_OUT_W-1:0] out_row_address,
  output logic [COL_W-1:0]     out_column,
  output logic [PIXEL_W-1:0]   out_bits,
  output logic                 out_last
);

  localparam int DEPTH = PLANES * ROW_ADDRESSES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  lmsd_mem_ctl_t      mem_ctl;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [PIXEL_W-1:0] mem_wdata, mem_rdata;

  lmsd_scan_ctl #(
    .COLUMNS(COLUMNS), .ROW_ADDRESSES(ROW_ADDRESSES), .PLANES(PLANES),
    .DEPTH(DEPTH), .AW(AW)
  ) u_ctl (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_hold_plane, .in_plane,
    .in_row, .in_column, .in_pixel_bits,
    .out_valid, .out_ready, .out_row_address, .out_column, .out_bits, .out_last,
    .mem_ctl, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  lmsd_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk,
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: src/lmsd_checker.sv
// Port-level checks for the LED matrix scan driver, bound to the top level.
module lmsd_checker import lmsd_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [REQ_W-1:0]     in_req_type,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ROW_OUT_W-1:0] out_row_address,
  input logic [COL_W-1:0]     out_column,
  input logic [PIXEL_W-1:0]   out_bits,
  input logic                 out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_address) &&
      $stable(out_column) && $stable(out_bits) && $stable(out_last))
    else $error("stalled output item changed");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_column == COL_W'(COLUMNS - 1))
    else $error("last flag on wrong column");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_TICK |=> !in_ready)
    else $error("input accepted during scan");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind led_matrix_scan_driver lmsd_checker #(.COLUMNS(COLUMNS)) u_lmsd_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_req_type,
  .out_valid, .out_ready, .out_row_address, .out_column, .out_bits, .out_last
);

FILE: test/led_matrix_scan_driver_tb.sv
// Testbench for the LED matrix scan driver: directed table, then random items vs. predictor.
module led_matrix_scan_driver_tb;
  import lmsd_pkg::*;

  localparam int COLS   = COLUMNS_DEF;
  localparam int ROWS   = ROW_ADDRESSES_DEF;
  localparam int PLANES = PLANES_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 106;
  localparam int DIR_LEN    = 24;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row_address;
    logic [COL_W-1:0]     column;
    logic [PIXEL_W-1:0]   bits;
    logic                 last;
  } scan_pixel_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic               hold;
    logic               plane;
    logic [3:0]         row;
    logic [COL_W-1:0]   column;
    logic [PIXEL_W-1:0] bits;
  } request_t;

  // typed = 1: every pixel of the line is known, row address and fill given here
  typedef struct packed {
    request_t             rq;
    logic                 typed;
    logic [ROW_OUT_W-1:0] exp_row;
    logic [PIXEL_W-1:0]   exp_fill;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic                 in_hold_plane;
  logic                 in_plane;
  logic [3:0]           in_row;
  logic [COL_W-1:0]     in_column;
  logic [PIXEL_W-1:0]   in_pixel_bits;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROW_OUT_W-1:0] out_row_address;
  logic [COL_W-1:0]     out_column;
  logic [PIXEL_W-1:0]   out_bits;
  logic                 out_last;

  // predictor state
  logic [PIXEL_W-1:0] frame_mem [PLANES*ROWS*COLS];
  int                 line_ctr;
  int                 vis_plane;
  scan_pixel_t        pixel_q[$];
  int                 errors;

  logic                 typed_now;
  logic [ROW_OUT_W-1:0] typed_row;
  logic [PIXEL_W-1:0]   typed_fill;
  int                   tx_idle_pct;
  int                   rx_stall_pct;

  dir_row_t dir_table [DIR_LEN] = '{
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd0,  6'h00},
    '{'{REQ_WRITE,  1'b0, 1'b0, 4'd2,  6'd0,  6'h3F}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_WRITE,  1'b0, 1'b0, 4'd2,  6'd63, 6'h2A}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_WRITE,  1'b0, 1'b1, 4'd0,  6'd5,  6'h15}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_UNUSED, 1'b1, 1'b1, 4'd15, 6'd63, 6'h3F}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_SELECT, 1'b0, 1'b1, 4'd0,  6'd0,  6'h00}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd2,  6'h00},
    '{'{REQ_SELECT, 1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_WRITE,  1'b0, 1'b1, 4'd15, 6'd63, 6'h3F}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_WRITE,  1'b0, 1'b0, 4'd0,  6'd0,  6'h01}, 1'b0, 4'd0,  6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd3,  6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd4,  6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd5,  6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd6,  6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd7,  6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd8,  6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd9,  6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd10, 6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd11, 6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd12, 6'h00},
    '{'{REQ_TICK,   1'b1, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd13, 6'h00},
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b1, 4'd14, 6'h00},
    // row wrap without hold: shown plane flips to plane 1
    '{'{REQ_TICK,   1'b0, 1'b0, 4'd0,  6'd0,  6'h00}, 1'b0, 4'd0,  6'h00}
  };

  led_matrix_scan_driver DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_hold_plane, .in_plane, .in_row,
    .in_column, .in_pixel_bits,
    .out_valid, .out_ready, .out_row_address, .out_column, .out_bits, .out_last
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int frame_index(int p, int r, int c);
    return (p * ROWS + r) * COLS + c;
  endfunction

  // advance the predicted state by one item and queue the pixels of any scan line
  task automatic apply_request(input request_t rq);
    int latched;
    int c;
    scan_pixel_t px;
    case (rq.req)
      REQ_WRITE: begin
        if (rq.plane < PLANES && rq.row < ROWS && rq.column < COLS)
          frame_mem[frame_index(int'(rq.plane), int'(rq.row), int'(rq.column))] = rq.bits;
      end
      REQ_SELECT: begin
        if (rq.plane < PLANES) vis_plane = int'(rq.plane);
      end
      REQ_TICK: begin
        latched = line_ctr;
        line_ctr++;
        if (line_ctr >= ROWS) begin
          line_ctr = 0;
          if (!rq.hold) vis_plane = (vis_plane + 1 >= PLANES) ? 0 : vis_plane + 1;
        end
        for (c = 0; c < COLS; c++) begin
          px.row_address = typed_now ? typed_row : latched[ROW_OUT_W-1:0];
          px.column      = c[COL_W-1:0];
          px.bits        = typed_now ? typed_fill
                                     : frame_mem[frame_index(vis_plane, line_ctr, c)];
          px.last        = (c == COLS - 1);
          pixel_q.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    scan_pixel_t want;
    if (rst_n && in_valid && in_ready)
      apply_request({in_req_type, in_hold_plane, in_plane, in_row, in_column, in_pixel_bits});
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel with none expected: row %0d col %0d bits %h last %b",
                 $time, out_row_address, out_column, out_bits, out_last);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (want.row_address !== out_row_address || want.column !== out_column ||
            want.bits !== out_bits || want.last !== out_last) begin
          $display({"%0t: mismatch exp row %0d col %0d bits %h last %b, ",
                    "got row %0d col %0d bits %h last %b"},
                   $time, want.row_address, want.column, want.bits, want.last,
                   out_row_address, out_column, out_bits, out_last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // entered and left at a falling edge; valid holds until the item is taken
  task automatic send_request(input request_t rq, input logic typed,
                              input logic [ROW_OUT_W-1:0] t_row,
                              input logic [PIXEL_W-1:0] t_fill);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq.req;
    in_hold_plane <= rq.hold;
    in_plane      <= rq.plane;
    in_row        <= rq.row;
    in_column     <= rq.column;
    in_pixel_bits <= rq.bits;
    typed_now     <= typed;
    typed_row     <= t_row;
    typed_fill    <= t_fill;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic request_t random_request();
    request_t rq;
    int pick;
    pick      = $urandom_range(0, 99);
    rq.hold   = 1'($urandom_range(0, 1));
    rq.plane  = 1'($urandom_range(0, 1));
    rq.row    = 4'($urandom_range(0, 15));
    rq.column = COL_W'($urandom_range(0, 63));
    rq.bits   = PIXEL_W'($urandom_range(0, 63));
    if (pick < 45) rq.req = REQ_TICK;
    else if (pick < 85) rq.req = REQ_WRITE;
    else if (pick < 95) rq.req = REQ_SELECT;
    else rq.req = REQ_UNUSED;
    // half the writes land on the line the next tick will show
    if (rq.req == REQ_WRITE && $urandom_range(0, 1)) begin
      rq.plane = vis_plane[0];
      rq.row   = 4'((line_ctr + 1) % ROWS);
    end
    return rq;
  endfunction

  initial begin
    int k;
    errors       = 0;
    line_ctr     = 0;
    vis_plane    = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (k = 0; k < PLANES * ROWS * COLS; k++) frame_mem[k] = BLANK_PIXEL;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_TICK;
    in_hold_plane = 1'b0;
    in_plane      = 1'b0;
    in_row        = '0;
    in_column     = '0;
    in_pixel_bits = '0;
    typed_now     = 1'b0;
    typed_row     = '0;
    typed_fill    = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_LEN; k++)
      send_request(dir_table[k].rq, dir_table[k].typed, dir_table[k].exp_row,
                   dir_table[k].exp_fill);

    for (k = 0; k < RAND_ITEMS; k++) begin
      case (k * 4 / RAND_ITEMS)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      send_request(random_request(), 1'b0, '0, '0);
    end
    in_valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
